FILE: hw/rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, command and action codes, and signal numbers for the
// process signal controller.
// ----------------------------------------------------------------------------
package psc_pkg;

   // Default sizing handed to the top level
   localparam int unsigned DEF_PROCESSES     = 64;
   localparam int unsigned DEF_SIGNALS       = 32;
   localparam int unsigned DEF_HANDLER_WIDTH = 32;

   // Request command codes
   localparam logic [2:0] CMD_SEND        = 3'd0;
   localparam logic [2:0] CMD_SET_HANDLER = 3'd1;
   localparam logic [2:0] CMD_BLOCK       = 3'd2;
   localparam logic [2:0] CMD_UNBLOCK     = 3'd3;
   localparam logic [2:0] CMD_CHECK       = 3'd4;

   // Check result action codes
   localparam logic [2:0] ACT_NONE           = 3'd0;
   localparam logic [2:0] ACT_DEFAULT_IGNORE = 3'd1;
   localparam logic [2:0] ACT_TERMINATE      = 3'd2;
   localparam logic [2:0] ACT_STOP           = 3'd3;
   localparam logic [2:0] ACT_HANDLER        = 3'd4;

   // Signals with fixed meaning
   localparam int unsigned SIG_KILL  = 9;
   localparam int unsigned SIG_CHILD = 17;
   localparam int unsigned SIG_CONT  = 18;
   localparam int unsigned SIG_STOP  = 19;

   // Special handler words
   localparam int unsigned H_DEFAULT = 0;
   localparam int unsigned H_IGNORE  = 1;

   // Exit code offset for a terminating signal
   localparam logic [7:0] EXIT_BASE = 8'd128;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  process_id;
      logic [5:0]  signal_number;
      logic [31:0] handler_value;
      logic [31:0] signal_mask;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] previous_value;
      logic [2:0]  action;
      logic [4:0]  delivered_signal;
      logic [7:0]  exit_code;
      logic [31:0] handler_address;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_en;
      logic req_load;
      logic fetch;
      logic exec;
      logic scan_run;
      logic wback;
      logic rsp_load;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_done;
      logic check_go;
      logic scan_done;
   } dp_sts_type;

endpackage

FILE: hw/rtl/psc_dpath.sv
// ----------------------------------------------------------------------------
// psc_dpath
// Datapath: pending, blocked and handler memories, request decode, the
// signal scan pipeline for check requests, and the result registers.
// ----------------------------------------------------------------------------
module psc_dpath import psc_pkg::*; #(
   parameter int unsigned PROCESSES     = DEF_PROCESSES,
   parameter int unsigned SIGNALS       = DEF_SIGNALS,
   parameter int unsigned HANDLER_WIDTH = DEF_HANDLER_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   input  dp_cmd_type cmd,
   output dp_sts_type sts,
   input  req_type    req_data,
   output rsp_type    rsp_data
);

   localparam int unsigned PW     = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
   localparam int unsigned SW     = $clog2(SIGNALS);
   localparam int unsigned HAW    = PW + SW;
   localparam int unsigned PDEPTH = 1 << PW;
   localparam int unsigned HDEPTH = 1 << HAW;
   localparam logic [SW-1:0] LAST_SIG = SW'(SIGNALS - 1);

   // Request and clearing counter
   req_type           req_ff;
   logic [HAW-1:0]    clr_cnt_ff, clr_cnt_in;

   // Memories and their registered read data
   logic [SIGNALS-1:0]       pend_mem [PDEPTH];
   logic [SIGNALS-1:0]       blk_mem  [PDEPTH];
   logic [HANDLER_WIDTH-1:0] hnd_mem  [HDEPTH];
   logic [SIGNALS-1:0]       pend_rd_ff, blk_rd_ff;
   logic [HANDLER_WIDTH-1:0] hnd_rd_ff;

   // Scan pipeline
   logic [SIGNALS-1:0] ready_ff, pend_work_ff;
   logic [SW-1:0]      scan_cnt_ff, eval_sig_ff;
   logic               eval_bit_ff, eval_last_ff;
   logic               eval_vld_ff, eval_vld_in;

   // Results
   rsp_type res_ff, rsp_ff;

   // Decode
   logic [PW-1:0]            pid_idx;
   logic [SW-1:0]            sig_idx;
   logic [HAW-1:0]           hnd_raddr;
   logic                     pid_ok, sig_ok, sig_catch, cmd_ok, check_go;
   logic [SIGNALS-1:0]       smask_w, ublk, blk_set, blk_clr, pend_send, blk_wdata;
   logic [HANDLER_WIDTH-1:0] hval_w;
   logic                     pend_we, blk_we, hnd_we;
   rsp_type                  exec_res, scan_res;
   logic                     eval_ign, eval_dflt, eval_hit, scan_done;

   assign pid_idx   = req_ff.process_id[PW-1:0];
   assign sig_idx   = req_ff.signal_number[SW-1:0];
   assign pid_ok    = 32'(req_ff.process_id) < PROCESSES;
   assign sig_ok    = (req_ff.signal_number != 6'd0) &&
                      (32'(req_ff.signal_number) < SIGNALS);
   assign sig_catch = sig_ok && (req_ff.signal_number != 6'(SIG_KILL)) &&
                      (req_ff.signal_number != 6'(SIG_STOP));
   assign cmd_ok    = pid_ok && (req_ff.command <= CMD_CHECK);
   assign check_go  = cmd_ok && (req_ff.command == CMD_CHECK);
   assign smask_w   = SIGNALS'(req_ff.signal_mask);
   assign hval_w    = HANDLER_WIDTH'(req_ff.handler_value);

   // Kill and stop can never be blocked
   always_comb begin
      ublk           = '0;
      ublk[SIG_KILL] = 1'b1;
      ublk[SIG_STOP] = 1'b1;
   end

   assign blk_set   = (blk_rd_ff | smask_w) & ~ublk;
   assign blk_clr   = blk_rd_ff & ~smask_w;
   assign pend_send = pend_rd_ff | (SIGNALS'(1) << sig_idx);

   // Execute non-check commands: result and write enables
   always_comb begin
      exec_res  = '0;
      pend_we   = 1'b0;
      blk_we    = 1'b0;
      hnd_we    = 1'b0;
      blk_wdata = blk_set;
      if (!cmd_ok) begin
         exec_res.status = 1'b1;
      end else begin
         case (req_ff.command)
            CMD_SEND: begin
               if (sig_ok) begin
                  pend_we = 1'b1;
               end else begin
                  exec_res.status = 1'b1;
               end
            end
            CMD_SET_HANDLER: begin
               if (sig_catch) begin
                  hnd_we                  = 1'b1;
                  exec_res.previous_value = 32'(hnd_rd_ff);
               end else begin
                  exec_res.status = 1'b1;
               end
            end
            CMD_BLOCK: begin
               blk_we                  = 1'b1;
               exec_res.previous_value = 32'(blk_rd_ff);
            end
            CMD_UNBLOCK: begin
               blk_we                  = 1'b1;
               blk_wdata               = blk_clr;
               exec_res.previous_value = 32'(blk_rd_ff);
            end
            default: begin
            end
         endcase
      end
   end

   // Evaluate the handler word of the signal read last cycle
   assign eval_ign  = hnd_rd_ff == HANDLER_WIDTH'(H_IGNORE);
   assign eval_dflt = hnd_rd_ff == HANDLER_WIDTH'(H_DEFAULT);
   assign eval_hit  = eval_vld_ff && eval_bit_ff && !eval_ign;
   assign scan_done = eval_hit || (eval_vld_ff && eval_last_ff);

   always_comb begin
      scan_res = '0;
      if (eval_hit) begin
         scan_res.delivered_signal = 5'(eval_sig_ff);
         if (eval_dflt) begin
            if ((eval_sig_ff == SW'(SIG_CHILD)) || (eval_sig_ff == SW'(SIG_CONT))) begin
               scan_res.action = ACT_DEFAULT_IGNORE;
            end else if (eval_sig_ff == SW'(SIG_STOP)) begin
               scan_res.action = ACT_STOP;
            end else begin
               scan_res.action    = ACT_TERMINATE;
               scan_res.exit_code = EXIT_BASE + 8'(eval_sig_ff);
            end
         end else begin
            scan_res.action          = ACT_HANDLER;
            scan_res.handler_address = 32'(hnd_rd_ff);
         end
      end
   end

   // Capture request
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_data;
      end
   end

   // Advance clearing counter
   assign clr_cnt_in = cmd.clear_en ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Pending memory
   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         pend_mem[clr_cnt_ff[HAW-1:SW]] <= '0;
      end else if (cmd.exec && pend_we) begin
         pend_mem[pid_idx] <= pend_send;
      end else if (cmd.wback) begin
         pend_mem[pid_idx] <= pend_work_ff;
      end
      if (cmd.fetch) begin
         pend_rd_ff <= pend_mem[pid_idx];
      end
   end

   // Blocked memory
   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         blk_mem[clr_cnt_ff[HAW-1:SW]] <= '0;
      end else if (cmd.exec && blk_we) begin
         blk_mem[pid_idx] <= blk_wdata;
      end
      if (cmd.fetch) begin
         blk_rd_ff <= blk_mem[pid_idx];
      end
   end

   // Handler memory, read by request signal or by scan position
   assign hnd_raddr = cmd.scan_run ? {pid_idx, scan_cnt_ff} : {pid_idx, sig_idx};

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         hnd_mem[clr_cnt_ff] <= '0;
      end else if (cmd.exec && hnd_we) begin
         hnd_mem[{pid_idx, sig_idx}] <= hval_w;
      end
      if (cmd.fetch || cmd.scan_run) begin
         hnd_rd_ff <= hnd_mem[hnd_raddr];
      end
   end

   // Scan: issue one signal per cycle, drop ready pending bits as they are visited
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         pend_work_ff <= pend_rd_ff;
         ready_ff     <= pend_rd_ff & ~blk_rd_ff;
         scan_cnt_ff  <= SW'(1);
      end else if (cmd.scan_run) begin
         eval_sig_ff  <= scan_cnt_ff;
         eval_bit_ff  <= ready_ff[scan_cnt_ff];
         eval_last_ff <= scan_cnt_ff == LAST_SIG;
         if (scan_cnt_ff != LAST_SIG) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
         if (eval_vld_ff && eval_bit_ff) begin
            pend_work_ff[eval_sig_ff] <= 1'b0;
         end
      end
   end

   always_comb begin
      eval_vld_in = eval_vld_ff;
      if (cmd.exec) begin
         eval_vld_in = 1'b0;
      end else if (cmd.scan_run) begin
         eval_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_vld_ff <= 1'b0;
      end else begin
         eval_vld_ff <= eval_vld_in;
      end
   end

   // Hold result until the output register is free
   always_ff @(posedge clock) begin
      if (cmd.exec && !check_go) begin
         res_ff <= exec_res;
      end else if (cmd.scan_run && scan_done) begin
         res_ff <= scan_res;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign sts.clear_done = clr_cnt_ff == '1;
   assign sts.check_go   = check_go;
   assign sts.scan_done  = scan_done;
   assign rsp_data       = rsp_ff;

endmodule

FILE: hw/rtl/psc_ctrl.sv
// ----------------------------------------------------------------------------
// psc_ctrl
// Controller: sequences the clearing pass, request fetch, execute, signal
// scan and write-back, and owns the request and response handshakes.
// ----------------------------------------------------------------------------
module psc_ctrl import psc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_EXEC  = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_WBACK = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.check_go ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_WBACK;
            end
         end
         ST_WBACK: begin
            cmd.wback = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("psc_ctrl: more than one datapath command");

   a_accept_fetch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_FETCH))
      else $error("psc_ctrl: accepted request not fetched");

   a_scan_wback: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && sts.scan_done) |=> (state_ff == ST_WBACK))
      else $error("psc_ctrl: scan end without write-back");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("psc_ctrl: response raised outside done state");

endmodule

FILE: hw/rtl/process_signal_controller.sv
// ----------------------------------------------------------------------------
// process_signal_controller
// Per-process signal controller: pending and blocked bitmaps plus one
// handler word per signal, driven by send, set handler, block, unblock and
// check requests.
//
// Usage:
//   Requests enter on req_valid/req_ready with a req_type payload; each
//   request gives exactly one response on rsp_valid/rsp_ready.
//   Send, set handler, block, unblock and rejected requests pass through
//   the fetch, execute and done steps; a new request can be taken in the
//   same cycle that rsp_valid rises. A check adds a scan step and a
//   write-back step: the handler memory is read one signal per cycle
//   through its single read port, until the signal reported or the last
//   signal is reached.
//   After reset the block clears all three memories, one handler word per
//   cycle, over PROCESSES rounded up to a power of two times 2**clog2(SIGNALS)
//   handler words; req_ready stays low until that is done.
//   The response sits in an output register: while the receiver stalls, the
//   next request is still accepted and processed, and waits in the done
//   step until the held response is taken.
// ----------------------------------------------------------------------------
module process_signal_controller import psc_pkg::*; #(
   parameter int unsigned PROCESSES     = DEF_PROCESSES,
   parameter int unsigned SIGNALS       = DEF_SIGNALS,
   parameter int unsigned HANDLER_WIDTH = DEF_HANDLER_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   // Sequencer
   psc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (dp_cmd),
      .sts       (dp_sts)
   );

   // Storage and compute
   psc_dpath #(
      .PROCESSES     (PROCESSES),
      .SIGNALS       (SIGNALS),
      .HANDLER_WIDTH (HANDLER_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (dp_cmd),
      .sts      (dp_sts),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

FILE: test/tb_process_signal_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_process_signal_controller
// Self-checking bench for the process signal controller. A shadow copy of
// the pending, blocked and handler state predicts each response. Stimulus is
// a short directed pass over the corner cases, then random requests aimed
// at a few processes so that checks walk deep into the state. Both sides
// stall at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module tb_process_signal_controller;
   import psc_pkg::*;

   localparam int unsigned PROCESSES       = DEF_PROCESSES;
   localparam int unsigned SIGNALS         = DEF_SIGNALS;
   localparam int          PERIOD          = 10;
   localparam int          RESET_CYCLES    = 10;
   localparam int          RANDOM_REQUESTS = 1700;
   localparam int          MAX_WAIT        = 12;
   localparam int          DRAIN_CYCLES    = 64;
   localparam int          CYCLE_LIMIT     = 600000;
   localparam logic [31:0] NEVER_BLOCKED   = (32'd1 << SIG_KILL) | (32'd1 << SIG_STOP);

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int      cycle_count   = 0;
   int      requests_sent = 0;
   bit      quiet_phase [2];

   // Shadow signal state and the queue of responses it predicts
   class signal_state_board;
      bit [31:0] pending_mask [PROCESSES];
      bit [31:0] blocked_mask [PROCESSES];
      bit [31:0] handler_word [PROCESSES][SIGNALS];
      rsp_type   due_responses[$];
      int        mismatches;
      int        responses_seen;
      int        rejected;
      int        action_count [5];

      // Update the shadow state for one request and queue its response
      function void apply_request(req_type r);
         rsp_type     want;
         int unsigned p;
         int unsigned s;
         int unsigned n;
         bit          sig_ok;
         bit          done;
         bit [31:0]   ready_bits;
         want   = '0;
         p      = 32'(r.process_id);
         s      = 32'(r.signal_number);
         sig_ok = (s >= 1) && (s < SIGNALS);
         if (p >= PROCESSES) begin
            want.status = 1'b1;
         end else begin
            case (r.command)
               CMD_SEND: begin
                  if (!sig_ok) begin
                     want.status = 1'b1;
                  end else begin
                     pending_mask[p][s] = 1'b1;
                  end
               end
               CMD_SET_HANDLER: begin
                  if (!sig_ok || s == SIG_KILL || s == SIG_STOP) begin
                     want.status = 1'b1;
                  end else begin
                     want.previous_value = handler_word[p][s];
                     handler_word[p][s]  = r.handler_value;
                  end
               end
               CMD_BLOCK: begin
                  want.previous_value = blocked_mask[p];
                  blocked_mask[p] = (blocked_mask[p] | r.signal_mask) & ~NEVER_BLOCKED;
               end
               CMD_UNBLOCK: begin
                  want.previous_value = blocked_mask[p];
                  blocked_mask[p] = blocked_mask[p] & ~r.signal_mask;
               end
               CMD_CHECK: begin
                  // Walk upward, drop every deliverable bit seen, skip ignored ones
                  ready_bits = pending_mask[p] & ~blocked_mask[p];
                  done = 1'b0;
                  for (n = 1; n < SIGNALS; n++) begin
                     if (!done && ready_bits[n]) begin
                        pending_mask[p][n] = 1'b0;
                        if (handler_word[p][n] != H_IGNORE) begin
                           done = 1'b1;
                           want.delivered_signal = 5'(n);
                           if (handler_word[p][n] != H_DEFAULT) begin
                              want.action          = ACT_HANDLER;
                              want.handler_address = handler_word[p][n];
                           end else if (n == SIG_CHILD || n == SIG_CONT) begin
                              want.action = ACT_DEFAULT_IGNORE;
                           end else if (n == SIG_STOP) begin
                              want.action = ACT_STOP;
                           end else begin
                              want.action    = ACT_TERMINATE;
                              want.exit_code = EXIT_BASE + 8'(n);
                           end
                        end
                     end
                  end
                  action_count[want.action]++;
               end
               default: begin
                  want.status = 1'b1;
               end
            endcase
         end
         if (want.status) begin
            rejected++;
         end
         due_responses.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         end
      endfunction

      // Compare one response with the oldest prediction
      function void check_response(rsp_type got);
         rsp_type want;
         responses_seen++;
         if (due_responses.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response, expected none, got %h", $time, got);
            return;
         end
         want = due_responses.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("previous_value", want.previous_value, got.previous_value);
         compare_field("action", 32'(want.action), 32'(got.action));
         compare_field("delivered_signal", 32'(want.delivered_signal),
                       32'(got.delivered_signal));
         compare_field("exit_code", 32'(want.exit_code), 32'(got.exit_code));
         compare_field("handler_address", want.handler_address, got.handler_address);
      endfunction
   endclass

   signal_state_board board = new();

   process_signal_controller #(
      .PROCESSES     (PROCESSES),
      .SIGNALS       (SIGNALS),
      .HANDLER_WIDTH (DEF_HANDLER_WIDTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** process_signal_controller: FAILED **");
         $finish;
      end
   end

   // Draw a wait for one side, switching now and then into a stall-free stretch
   function automatic int draw_wait(int side);
      if ($urandom_range(0, 47) == 0) begin
         quiet_phase[side] = !quiet_phase[side];
      end
      return quiet_phase[side] ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic req_type pack_request(logic [2:0] cmd, logic [7:0] pid,
                                            logic [5:0] sig, logic [31:0] hval,
                                            logic [31:0] mask);
      req_type r;
      r.command       = cmd;
      r.process_id    = pid;
      r.signal_number = sig;
      r.handler_value = hval;
      r.signal_mask   = mask;
      return r;
   endfunction

   // Mostly legal requests on a few processes; the rest is noise
   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      r.handler_value = $urandom();
      r.signal_mask   = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 90) begin
         r.process_id = 8'($urandom_range(0, 7));
      end else if (pick < 95) begin
         r.process_id = 8'($urandom_range(0, PROCESSES - 1));
      end else begin
         r.process_id = 8'($urandom_range(PROCESSES, 255));
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         r.command = CMD_SEND;
      end else if (pick < 50) begin
         r.command = CMD_SET_HANDLER;
      end else if (pick < 60) begin
         r.command = CMD_BLOCK;
      end else if (pick < 70) begin
         r.command = CMD_UNBLOCK;
      end else if (pick < 95) begin
         r.command = CMD_CHECK;
      end else begin
         r.command = CMD_CHECK + 3'($urandom_range(1, 3));
      end
      if ($urandom_range(0, 9) == 0) begin
         r.signal_number = 6'($urandom_range(0, 63));
      end else begin
         r.signal_number = 6'($urandom_range(1, SIGNALS - 1));
      end
      pick = $urandom_range(0, 9);
      if (r.command == CMD_SET_HANDLER) begin
         if (pick < 3) begin
            r.handler_value = H_DEFAULT;
         end else if (pick < 6) begin
            r.handler_value = H_IGNORE;
         end
      end else if (r.command == CMD_BLOCK) begin
         if (pick < 5) begin
            r.signal_mask = 32'd1 << $urandom_range(0, 31);
         end else if (pick < 8) begin
            r.signal_mask = $urandom() & $urandom();
         end
      end else if (r.command == CMD_UNBLOCK) begin
         if (pick < 4) begin
            r.signal_mask = 32'd1 << $urandom_range(0, 31);
         end else if (pick < 6) begin
            r.signal_mask = '1;
         end
      end
      return r;
   endfunction

   // Present one request and hold it until the block takes it
   task automatic issue_request(input req_type r);
      int gap;
      gap = draw_wait(0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      board.apply_request(r);
      requests_sent++;
   endtask

   task automatic run_directed();
      req_type plan[$];
      plan.push_back(pack_request(CMD_CHECK, 8'd0, 6'd0, 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_SEND, 8'd0, 6'd0, 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_SEND, 8'd0, 6'd63, 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_SEND, 8'd64, 6'd1, 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_CHECK, 8'd255, 6'd1, 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_CHECK + 3'd1, 8'd0, 6'd1, 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_SET_HANDLER, 8'd0, 6'(SIG_KILL), 32'd7, 32'd0));
      plan.push_back(pack_request(CMD_SET_HANDLER, 8'd0, 6'(SIG_STOP), 32'd7, 32'd0));
      plan.push_back(pack_request(CMD_SET_HANDLER, 8'd0, 6'd5, 32'hFFFF_FFFF, 32'd0));
      plan.push_back(pack_request(CMD_SET_HANDLER, 8'd0, 6'd2, H_IGNORE, 32'd0));
      plan.push_back(pack_request(CMD_BLOCK, 8'd0, 6'd0, 32'd0, 32'hFFFF_FFFF));
      plan.push_back(pack_request(CMD_SEND, 8'd0, 6'd2, 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_SEND, 8'd0, 6'd5, 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_SEND, 8'd0, 6'(SIG_KILL), 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_SEND, 8'd0, 6'(SIG_CHILD), 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_SEND, 8'd0, 6'(SIG_CONT), 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_SEND, 8'd0, 6'(SIG_STOP), 32'd0, 32'd0));
      // Only kill and stop get past the full block
      plan.push_back(pack_request(CMD_CHECK, 8'd0, 6'd0, 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_UNBLOCK, 8'd0, 6'd0, 32'd0, 32'hFFFF_FFFF));
      plan.push_back(pack_request(CMD_CHECK, 8'd0, 6'd0, 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_CHECK, 8'd0, 6'd0, 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_CHECK, 8'd0, 6'd0, 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_CHECK, 8'd0, 6'd0, 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_SEND, 8'd63, 6'd31, 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_CHECK, 8'd63, 6'd0, 32'd0, 32'd0));
      // Everything pending is ignored: check clears it and reports nothing
      plan.push_back(pack_request(CMD_SET_HANDLER, 8'd1, 6'd31, H_IGNORE, 32'd0));
      plan.push_back(pack_request(CMD_SEND, 8'd1, 6'd31, 32'd0, 32'd0));
      plan.push_back(pack_request(CMD_CHECK, 8'd1, 6'd0, 32'd0, 32'd0));
      foreach (plan[i]) begin
         issue_request(plan[i]);
      end
   endtask

   // Response side: stall at random, then take and check each response
   initial begin
      rsp_type got;
      int      gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      @(posedge clock);
      forever begin
         gap = draw_wait(1);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
         while (!rsp_valid) @(negedge clock);
         got = rsp_data;
         @(posedge clock);
         board.check_response(got);
      end
   end

   // Request side and end of run
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      repeat (RANDOM_REQUESTS) begin
         issue_request(random_request());
      end
      req_valid <= 1'b0;
      while (board.due_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests (%0d rejected), checked %0d responses.",
               requests_sent, board.rejected, board.responses_seen);
      $display("Check outcomes: none %0d, default ignore %0d, terminate %0d, stop %0d, handler %0d.",
               board.action_count[ACT_NONE], board.action_count[ACT_DEFAULT_IGNORE],
               board.action_count[ACT_TERMINATE], board.action_count[ACT_STOP],
               board.action_count[ACT_HANDLER]);
      if (board.mismatches == 0) begin
         $display("** process_signal_controller: PASSED **");
      end else begin
         $display("** process_signal_controller: FAILED **");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/psc_pkg.sv
hw/rtl/psc_dpath.sv
hw/rtl/psc_ctrl.sv
hw/rtl/process_signal_controller.sv
test/tb_process_signal_controller.sv
